@@ sv/vpp_pkg.sv @@
// ----------------------------------------------------------------------------
// vpp_pkg
// Types, constants and width helpers shared by the vertex projection pipeline.
// ----------------------------------------------------------------------------
package vpp_pkg;

   localparam int SCALE_BASE  = 5;
   localparam int DEPTH_MUL   = 10000;
   localparam int PERSP_LIMIT = 10000;
   localparam int SCREEN_MOD  = 32767;
   localparam int QUOT_BITS   = 32;
   localparam int CSR_IDX_W   = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MATRIX_ROW0 = 4'd0,
      REG_MATRIX_ROW1 = 4'd1,
      REG_MATRIX_ROW2 = 4'd2,
      REG_OFFSET_X    = 4'd3,
      REG_OFFSET_Y    = 4'd4,
      REG_OFFSET_Z    = 4'd5,
      REG_DEPTH       = 4'd6,
      REG_HALF_VIEW   = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
   } vpp_req_type;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic signed [31:0] depth_out;
   } vpp_rsp_type;

   typedef struct packed {
      logic        [59:0] matrix_row0;
      logic        [59:0] matrix_row1;
      logic        [59:0] matrix_row2;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
      logic        [31:0] depth_perception;
      logic        [31:0] half_view_size;
   } vpp_cfg_type;

   localparam vpp_cfg_type CFG_RESET = '{
      matrix_row0:      60'd65536,
      matrix_row1:      60'd68719476736,
      matrix_row2:      60'd72057594037927936,
      offset_x:         32'sd0,
      offset_y:         32'sd0,
      offset_z:         32'sd0,
      depth_perception: 32'd655360000,
      half_view_size:   32'd0
   };

   // rounded transform result, signed
   function automatic int vpp_rw(int frac, int ent);
      return ent + 36 - frac;
   endfunction

   // perspective denominator, unsigned
   function automatic int vpp_dw(int frac, int ent);
      int rmw;
      rmw = vpp_rw(frac, ent) - 1;
      return ((rmw > 32) ? rmw : 32) + 1;
   endfunction

   // dividend
   function automatic int vpp_aw(int frac, int ent);
      int nw;
      int mw;
      nw = vpp_rw(frac, ent) + 35;
      mw = vpp_dw(frac, ent) + frac;
      return ((nw > mw) ? nw : mw) + 1;
   endfunction

   // divisor
   function automatic int vpp_bw(int frac, int ent);
      return vpp_dw(frac, ent) + frac + 1;
   endfunction

endpackage

@@ sv/vpp_csr.sv @@
// ----------------------------------------------------------------------------
// vpp_csr
// Configuration register file.
// ----------------------------------------------------------------------------
module vpp_csr
   import vpp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [59:0]          csr_wdata,
   output vpp_cfg_type          cfg
);

   vpp_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MATRIX_ROW0: cfg_ff.matrix_row0 <= csr_wdata;
            REG_MATRIX_ROW1: cfg_ff.matrix_row1 <= csr_wdata;
            REG_MATRIX_ROW2: cfg_ff.matrix_row2 <= csr_wdata;
            REG_OFFSET_X:    cfg_ff.offset_x <= csr_wdata[31:0];
            REG_OFFSET_Y:    cfg_ff.offset_y <= csr_wdata[31:0];
            REG_OFFSET_Z:    cfg_ff.offset_z <= csr_wdata[31:0];
            REG_DEPTH:       cfg_ff.depth_perception <= csr_wdata[31:0];
            REG_HALF_VIEW:   cfg_ff.half_view_size <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

@@ sv/vpp_xform.sv @@
// ----------------------------------------------------------------------------
// vpp_xform
// Translate, 3x3 matrix multiply and round: four register stages.
// ----------------------------------------------------------------------------
module vpp_xform
   import vpp_pkg::*;
#(
   parameter  int FRAC_BITS          = 16,
   parameter  int MATRIX_ENTRY_WIDTH = 20,
   localparam int RW                 = vpp_rw(FRAC_BITS, MATRIX_ENTRY_WIDTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  vpp_req_type          in_data,
   input  vpp_cfg_type          cfg,
   output logic                 out_valid,
   output logic signed [RW-1:0] rx,
   output logic signed [RW-1:0] ry,
   output logic signed [RW-1:0] rz
);

   localparam int E  = MATRIX_ENTRY_WIDTH;
   localparam int PW = E + 33;
   localparam int SW = PW + 2;
   localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

   logic [3:0]              vld_ff;
   logic signed [32:0]      v_ff [3];
   logic signed [32:0]      v_in [3];
   logic signed [PW-1:0]    p_ff [3][3];
   logic signed [PW-1:0]    p_in [3][3];
   logic signed [SW-1:0]    s_ff [3];
   logic signed [SW-1:0]    s_in [3];
   logic signed [RW-1:0]    r_ff [3];
   logic signed [RW-1:0]    r_in [3];
   logic [62:0]             row_ext [3];
   logic signed [E-1:0]     ent [3][3];
   logic [SW-1:0]           s_mag [3];
   logic [SW-1:0]           s_rnd [3];

   always_comb begin
      row_ext[0] = {3'b000, cfg.matrix_row0};
      row_ext[1] = {3'b000, cfg.matrix_row1};
      row_ext[2] = {3'b000, cfg.matrix_row2};
      v_in[0] = 33'(in_data.vertex_x) + 33'(cfg.offset_x);
      v_in[1] = 33'(in_data.vertex_y) + 33'(cfg.offset_y);
      v_in[2] = 33'(in_data.vertex_z) + 33'(cfg.offset_z);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            ent[r][c]  = row_ext[r][c*E +: E];
            p_in[r][c] = PW'(ent[r][c]) * PW'(v_ff[c]);
         end
         s_in[r]  = SW'(p_ff[r][0]) + SW'(p_ff[r][1]) + SW'(p_ff[r][2]);
         s_mag[r] = s_ff[r][SW-1] ? SW'(-s_ff[r]) : SW'(s_ff[r]);
         s_rnd[r] = s_mag[r] + HALF;
         r_in[r]  = s_ff[r][SW-1] ? -$signed(RW'(s_rnd[r] >> FRAC_BITS))
                                  :  $signed(RW'(s_rnd[r] >> FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
      v_ff <= v_in;
      p_ff <= p_in;
      s_ff <= s_in;
      r_ff <= r_in;
   end

   assign out_valid = vld_ff[3];
   assign rx        = r_ff[0];
   assign ry        = r_ff[1];
   assign rz        = r_ff[2];

endmodule

@@ sv/vpp_setup.sv @@
// ----------------------------------------------------------------------------
// vpp_setup
// Perspective select, scaled numerators, divisor and depth: four stages.
// ----------------------------------------------------------------------------
module vpp_setup
   import vpp_pkg::*;
#(
   parameter  int FRAC_BITS          = 16,
   parameter  int MATRIX_ENTRY_WIDTH = 20,
   localparam int RW = vpp_rw(FRAC_BITS, MATRIX_ENTRY_WIDTH),
   localparam int AW = vpp_aw(FRAC_BITS, MATRIX_ENTRY_WIDTH),
   localparam int BW = vpp_bw(FRAC_BITS, MATRIX_ENTRY_WIDTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [RW-1:0] rx,
   input  logic signed [RW-1:0] ry,
   input  logic signed [RW-1:0] rz,
   input  vpp_cfg_type          cfg,
   output logic                 out_valid,
   output logic [AW-1:0]        num_x,
   output logic [AW-1:0]        num_y,
   output logic [BW-1:0]        den,
   output logic                 neg_x,
   output logic                 neg_y,
   output logic signed [31:0]   depth
);

   localparam int RMW = RW - 1;
   localparam int DW  = vpp_dw(FRAC_BITS, MATRIX_ENTRY_WIDTH);
   localparam int PPW = RMW + 32;
   localparam int ZW  = RMW + 14;
   localparam int ZRW = ZW + 1;
   localparam logic [63:0]    LIMIT   = 64'(PERSP_LIMIT) << FRAC_BITS;
   localparam logic [ZRW-1:0] Z_HALF  = ZRW'(1) << (FRAC_BITS - 1);
   localparam logic [31:0]    POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0]    NEG_MAX = 32'h8000_0000;

   logic [3:0] vld_ff;

   // stage A
   logic signed [DW:0]  r2e;
   logic signed [DW:0]  de;
   logic signed [DW:0]  dsum;
   logic                persp;
   logic [RW-1:0]       ax_a;
   logic [RW-1:0]       ay_a;
   logic [RW-1:0]       az_a;
   logic [31:0]         deff_ff, deff_in;
   logic [DW-1:0]       den_a_ff, den_a_in;
   logic [RMW-1:0]      mx_ff, my_ff;
   logic [ZW-1:0]       zp_ff, zp_in;
   logic [2:0]          neg_a_ff;

   // stage B
   logic [63:0]         mx64, my64;
   logic [63:0]         plo_x_ff, phi_x_ff, plo_y_ff, phi_y_ff;
   logic [DW-1:0]       den_b_ff;
   logic [1:0]          neg_b_ff;
   logic [ZRW-1:0]      zr;
   logic [31:0]         zlim;
   logic [31:0]         zmag;
   logic signed [31:0]  dz_b_ff, dz_b_in;

   // stage C
   logic [PPW-1:0]      px_ff, py_ff;
   logic [DW-1:0]       den_c_ff;
   logic [1:0]          neg_c_ff;
   logic signed [31:0]  dz_c_ff;

   // stage D
   logic [AW-1:0]       ax_ff, ay_ff;
   logic [BW-1:0]       b_ff;
   logic [1:0]          neg_d_ff;
   logic signed [31:0]  dz_d_ff;

   always_comb begin
      r2e      = (DW+1)'(rz);
      de       = $signed((DW+1)'(cfg.depth_perception));
      dsum     = r2e + de;
      persp    = ({32'h0, cfg.depth_perception} < LIMIT) && (dsum > 0);
      deff_in  = persp ? cfg.depth_perception : 32'd1;
      den_a_in = persp ? DW'(dsum) : DW'(1);
      ax_a     = rx[RW-1] ? RW'(-rx) : RW'(rx);
      ay_a     = ry[RW-1] ? RW'(-ry) : RW'(ry);
      az_a     = rz[RW-1] ? RW'(-rz) : RW'(rz);
      zp_in    = ZW'(az_a[RMW-1:0]) * ZW'(DEPTH_MUL);

      mx64     = 64'(mx_ff);
      my64     = 64'(my_ff);
      zr       = (ZRW'(zp_ff) + Z_HALF) >> FRAC_BITS;
      zlim     = neg_a_ff[2] ? NEG_MAX : POS_MAX;
      zmag     = (zr > ZRW'(zlim)) ? zlim : zr[31:0];
      dz_b_in  = neg_a_ff[2] ? -$signed(zmag) : $signed(zmag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
      deff_ff  <= deff_in;
      den_a_ff <= den_a_in;
      mx_ff    <= ax_a[RMW-1:0];
      my_ff    <= ay_a[RMW-1:0];
      zp_ff    <= zp_in;
      neg_a_ff <= {rz[RW-1], ry[RW-1], rx[RW-1]};

      plo_x_ff <= mx64[31:0] * deff_ff;
      phi_x_ff <= mx64[63:32] * deff_ff;
      plo_y_ff <= my64[31:0] * deff_ff;
      phi_y_ff <= my64[63:32] * deff_ff;
      den_b_ff <= den_a_ff;
      neg_b_ff <= neg_a_ff[1:0];
      dz_b_ff  <= dz_b_in;

      px_ff    <= PPW'({phi_x_ff, 32'h0} + {32'h0, plo_x_ff});
      py_ff    <= PPW'({phi_y_ff, 32'h0} + {32'h0, plo_y_ff});
      den_c_ff <= den_b_ff;
      neg_c_ff <= neg_b_ff;
      dz_c_ff  <= dz_b_ff;

      // 2 * 5 * P + (D << F)
      ax_ff    <= (AW'(px_ff) << 3) + (AW'(px_ff) << 1) + (AW'(den_c_ff) << FRAC_BITS);
      ay_ff    <= (AW'(py_ff) << 3) + (AW'(py_ff) << 1) + (AW'(den_c_ff) << FRAC_BITS);
      b_ff     <= BW'(den_c_ff) << (FRAC_BITS + 1);
      neg_d_ff <= neg_c_ff;
      dz_d_ff  <= dz_c_ff;
   end

   assign out_valid = vld_ff[3];
   assign num_x     = ax_ff;
   assign num_y     = ay_ff;
   assign den       = b_ff;
   assign neg_x     = neg_d_ff[0];
   assign neg_y     = neg_d_ff[1];
   assign depth     = dz_d_ff;

endmodule

@@ sv/vpp_div.sv @@
// ----------------------------------------------------------------------------
// vpp_div
// Pipelined restoring divider, two lanes sharing one divisor, one quotient
// bit per stage, with an overflow check ahead of the first stage.
// ----------------------------------------------------------------------------
module vpp_div
   import vpp_pkg::*;
#(
   parameter int AW = 76,
   parameter int BW = 57
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [AW-1:0]        num_x,
   input  logic [AW-1:0]        num_y,
   input  logic [BW-1:0]        den,
   input  logic                 neg_x_i,
   input  logic                 neg_y_i,
   input  logic signed [31:0]   depth_i,
   output logic                 out_valid,
   output logic [QUOT_BITS-1:0] quo_x,
   output logic [QUOT_BITS-1:0] quo_y,
   output logic                 ovf_x,
   output logic                 ovf_y,
   output logic                 neg_x_o,
   output logic                 neg_y_o,
   output logic signed [31:0]   depth_o
);

   localparam int QW = QUOT_BITS;
   localparam int CW = (AW > BW + QW) ? AW : BW + QW;

   logic [QW:0]          vld_ff;
   logic [AW-1:0]        rx_ff [QW+1];
   logic [AW-1:0]        rx_in [QW+1];
   logic [AW-1:0]        ry_ff [QW+1];
   logic [AW-1:0]        ry_in [QW+1];
   logic [QW-1:0]        qx_ff [QW+1];
   logic [QW-1:0]        qx_in [QW+1];
   logic [QW-1:0]        qy_ff [QW+1];
   logic [QW-1:0]        qy_in [QW+1];
   logic [BW-1:0]        b_ff  [QW+1];
   logic [1:0]           ovf_ff [QW+1];
   logic [1:0]           neg_ff [QW+1];
   logic signed [31:0]   dz_ff [QW+1];
   logic [CW-1:0]        trial [QW+1];

   always_comb begin
      trial[0] = CW'(den) << QW;
      rx_in[0] = num_x;
      ry_in[0] = num_y;
      qx_in[0] = '0;
      qy_in[0] = '0;
      for (int k = 1; k <= QW; k++) begin
         trial[k] = CW'(b_ff[k-1]) << (QW - k);
         rx_in[k] = rx_ff[k-1];
         qx_in[k] = qx_ff[k-1];
         if (CW'(rx_ff[k-1]) >= trial[k]) begin
            rx_in[k] = rx_ff[k-1] - AW'(trial[k]);
            qx_in[k] = qx_ff[k-1] | (QW'(1) << (QW - k));
         end
         ry_in[k] = ry_ff[k-1];
         qy_in[k] = qy_ff[k-1];
         if (CW'(ry_ff[k-1]) >= trial[k]) begin
            ry_in[k] = ry_ff[k-1] - AW'(trial[k]);
            qy_in[k] = qy_ff[k-1] | (QW'(1) << (QW - k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QW-1:0], in_valid};
      end
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      b_ff[0]   <= den;
      ovf_ff[0] <= {CW'(num_y) >= trial[0], CW'(num_x) >= trial[0]};
      neg_ff[0] <= {neg_y_i, neg_x_i};
      dz_ff[0]  <= depth_i;
      for (int k = 1; k <= QW; k++) begin
         b_ff[k]   <= b_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         dz_ff[k]  <= dz_ff[k-1];
      end
   end

   assign out_valid = vld_ff[QW];
   assign quo_x     = qx_ff[QW];
   assign quo_y     = qy_ff[QW];
   assign ovf_x     = ovf_ff[QW][0];
   assign ovf_y     = ovf_ff[QW][1];
   assign neg_x_o   = neg_ff[QW][0];
   assign neg_y_o   = neg_ff[QW][1];
   assign depth_o   = dz_ff[QW];

endmodule

@@ sv/vpp_screen.sv @@
// ----------------------------------------------------------------------------
// vpp_screen
// Saturate, add view centre, signed remainder by 32767 and output register.
// ----------------------------------------------------------------------------
module vpp_screen
   import vpp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [QUOT_BITS-1:0] quo_x,
   input  logic [QUOT_BITS-1:0] quo_y,
   input  logic                 ovf_x,
   input  logic                 ovf_y,
   input  logic                 neg_x,
   input  logic                 neg_y,
   input  logic signed [31:0]   depth,
   input  vpp_cfg_type          cfg,
   output logic                 rsp_strobe,
   output vpp_rsp_type          rsp_data
);

   localparam logic [31:0]        POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0]        NEG_MAX = 32'h8000_0000;
   localparam logic signed [33:0] HI_SAT  = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] LO_SAT  = -34'sh0_8000_0000;
   localparam logic [15:0]        MOD     = 16'(SCREEN_MOD);

   logic [1:0]         vld_ff;

   logic [31:0]        lim_x, lim_y, mag_x, mag_y;
   logic signed [32:0] xq_ff, xq_in, yq_ff, yq_in;
   logic signed [31:0] dz1_ff;

   logic signed [33:0] sum_x, sum_y, cl_x, cl_y;
   logic [31:0]        am_ff [2];
   logic [31:0]        am_in [2];
   logic [1:0]         an_ff;
   logic signed [31:0] dz2_ff;

   logic [16:0]        fold1 [2];
   logic [15:0]        fold2 [2];
   logic [15:0]        rem [2];
   logic signed [15:0] scr [2];
   logic               strobe_ff;
   vpp_rsp_type        rsp_ff;

   always_comb begin
      lim_x = neg_x ? NEG_MAX : POS_MAX;
      lim_y = neg_y ? NEG_MAX : POS_MAX;
      mag_x = (ovf_x || (quo_x > lim_x)) ? lim_x : quo_x;
      mag_y = (ovf_y || (quo_y > lim_y)) ? lim_y : quo_y;
      xq_in = neg_x ? -$signed(33'(mag_x)) : $signed(33'(mag_x));
      yq_in = neg_y ? -$signed(33'(mag_y)) : $signed(33'(mag_y));

      sum_x = 34'(xq_ff) + $signed(34'(cfg.half_view_size[15:0]));
      sum_y = $signed(34'(cfg.half_view_size[31:16])) - 34'(yq_ff);
      cl_x  = (sum_x > HI_SAT) ? HI_SAT : ((sum_x < LO_SAT) ? LO_SAT : sum_x);
      cl_y  = (sum_y > HI_SAT) ? HI_SAT : ((sum_y < LO_SAT) ? LO_SAT : sum_y);
      am_in[0] = cl_x[33] ? 32'(-cl_x) : 32'(cl_x);
      am_in[1] = cl_y[33] ? 32'(-cl_y) : 32'(cl_y);

      // 2^15 = 1 mod 32767: fold 15-bit digits
      for (int i = 0; i < 2; i++) begin
         fold1[i] = 17'(am_ff[i][14:0]) + 17'(am_ff[i][29:15]) + 17'(am_ff[i][31:30]);
         fold2[i] = 16'(fold1[i][14:0]) + 16'(fold1[i][16:15]);
         rem[i]   = (fold2[i] >= MOD) ? fold2[i] - MOD : fold2[i];
         scr[i]   = an_ff[i] ? -$signed(rem[i]) : $signed(rem[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff    <= {vld_ff[0], in_valid};
         strobe_ff <= vld_ff[1];
      end
      xq_ff  <= xq_in;
      yq_ff  <= yq_in;
      dz1_ff <= depth;
      am_ff  <= am_in;
      an_ff  <= {cl_y[33], cl_x[33]};
      dz2_ff <= dz1_ff;
      rsp_ff.screen_x  <= scr[0];
      rsp_ff.screen_y  <= scr[1];
      rsp_ff.depth_out <= dz2_ff;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ sv/vertex_perspective_project.sv @@
// ----------------------------------------------------------------------------
// vertex_perspective_project
// Translate, transform and perspective-project one vertex per clock.
// ----------------------------------------------------------------------------
// A request is taken in every cycle that start is high; busy is never raised.
// Each request gives one result on rsp_strobe, in order, and the pipeline
// holds up to 44 requests in flight. Latency is set by the 33-stage
// restoring divider (overflow check plus one quotient bit per stage) that
// forms the perspective scale, behind four transform and four setup stages,
// and ahead of three output stages. Results cannot be held off.
// ----------------------------------------------------------------------------
module vertex_perspective_project
   import vpp_pkg::*;
#(
   parameter int FRAC_BITS          = 16,
   parameter int MATRIX_ENTRY_WIDTH = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  vpp_req_type          req_data,
   output logic                 rsp_strobe,
   output vpp_rsp_type          rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [59:0]          csr_wdata
);

   localparam int RW = vpp_rw(FRAC_BITS, MATRIX_ENTRY_WIDTH);
   localparam int AW = vpp_aw(FRAC_BITS, MATRIX_ENTRY_WIDTH);
   localparam int BW = vpp_bw(FRAC_BITS, MATRIX_ENTRY_WIDTH);

   vpp_cfg_type          cfg;
   logic                 xf_valid;
   logic signed [RW-1:0] rx, ry, rz;
   logic                 su_valid;
   logic [AW-1:0]        num_x, num_y;
   logic [BW-1:0]        den;
   logic                 su_neg_x, su_neg_y;
   logic signed [31:0]   su_depth;
   logic                 dv_valid;
   logic [QUOT_BITS-1:0] quo_x, quo_y;
   logic                 ovf_x, ovf_y, dv_neg_x, dv_neg_y;
   logic signed [31:0]   dv_depth;

   assign busy = 1'b0;

   vpp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vpp_xform #(
      .FRAC_BITS          (FRAC_BITS),
      .MATRIX_ENTRY_WIDTH (MATRIX_ENTRY_WIDTH)
   ) u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (xf_valid),
      .rx        (rx),
      .ry        (ry),
      .rz        (rz)
   );

   vpp_setup #(
      .FRAC_BITS          (FRAC_BITS),
      .MATRIX_ENTRY_WIDTH (MATRIX_ENTRY_WIDTH)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xf_valid),
      .rx        (rx),
      .ry        (ry),
      .rz        (rz),
      .cfg       (cfg),
      .out_valid (su_valid),
      .num_x     (num_x),
      .num_y     (num_y),
      .den       (den),
      .neg_x     (su_neg_x),
      .neg_y     (su_neg_y),
      .depth     (su_depth)
   );

   vpp_div #(
      .AW (AW),
      .BW (BW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (su_valid),
      .num_x     (num_x),
      .num_y     (num_y),
      .den       (den),
      .neg_x_i   (su_neg_x),
      .neg_y_i   (su_neg_y),
      .depth_i   (su_depth),
      .out_valid (dv_valid),
      .quo_x     (quo_x),
      .quo_y     (quo_y),
      .ovf_x     (ovf_x),
      .ovf_y     (ovf_y),
      .neg_x_o   (dv_neg_x),
      .neg_y_o   (dv_neg_y),
      .depth_o   (dv_depth)
   );

   vpp_screen u_screen (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_valid),
      .quo_x      (quo_x),
      .quo_y      (quo_y),
      .ovf_x      (ovf_x),
      .ovf_y      (ovf_y),
      .neg_x      (dv_neg_x),
      .neg_y      (dv_neg_y),
      .depth      (dv_depth),
      .cfg        (cfg),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ sv/vpp_checker.sv @@
// ----------------------------------------------------------------------------
// vpp_checker
// Port-level checks on the projection block, bound to the top level.
// ----------------------------------------------------------------------------
module vpp_checker
   import vpp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input vpp_req_type          req_data,
   input logic                 rsp_strobe,
   input vpp_rsp_type          rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [59:0]          csr_wdata
);

   a_flush: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   a_sx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.screen_x >= -16'sd32766) && (rsp_data.screen_x <= 16'sd32766))
      else $error("screen_x outside remainder range");

   a_sy_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.screen_y >= -16'sd32766) && (rsp_data.screen_y <= 16'sd32766))
      else $error("screen_y outside remainder range");

endmodule

bind vertex_perspective_project vpp_checker u_vpp_checker (.*);
